### design/scl_pkg.sv
// Shared types, keyword tables and matching functions for the command line matcher.
`default_nettype none
package scl_pkg;

   typedef enum logic [3:0] {
      OUT_LED_ON     = 4'd0,
      OUT_LED_OFF    = 4'd1,
      OUT_LED_TOGGLE = 4'd2,
      OUT_LED_USAGE  = 4'd3,
      OUT_BAD_ARG    = 4'd4,
      OUT_HELP       = 4'd5,
      OUT_VERSION    = 4'd6,
      OUT_UNKNOWN    = 4'd7,
      OUT_TOO_LONG   = 4'd8
   } outcome_type;

   typedef struct packed {
      logic        have;
      outcome_type outcome;
      logic        led_level;
   } result_type;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   // candidate bits: names bit0 led, bit1 help, bit2 ver; args bit0 on, bit1 off, bit2 toggle
   localparam int KEY_COUNT = 3;

   localparam logic [2:0] NAME_LEN [KEY_COUNT] = '{3'd3, 3'd4, 3'd3};
   localparam logic [2:0] ARG_LEN  [KEY_COUNT] = '{3'd2, 3'd3, 3'd6};

   localparam logic [7:0] NAME_TEXT [KEY_COUNT][8] = '{
      '{"l", "e", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"h", "e", "l", "p",   8'h00, 8'h00, 8'h00, 8'h00},
      '{"v", "e", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };
   localparam logic [7:0] ARG_TEXT [KEY_COUNT][8] = '{
      '{"o", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"o", "f", "f",   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"t", "o", "g",   "g",   "l",   "e",   8'h00, 8'h00}
   };

   // drop candidates whose character at pos differs from c
   function automatic logic [2:0] narrow_set(input logic [2:0] set, input logic sel_args,
                                             input logic [2:0] pos, input logic [7:0] c);
      logic [2:0] r;
      logic [2:0] len;
      logic [7:0] ch;
      r = set;
      for (int k = 0; k < KEY_COUNT; k++) begin
         len = sel_args ? ARG_LEN[k] : NAME_LEN[k];
         ch  = sel_args ? ARG_TEXT[k][pos] : NAME_TEXT[k][pos];
         if ((pos >= len) || (ch != c)) begin
            r[k] = 1'b0;
         end
      end
      return r;
   endfunction

   // keep candidates whose length equals the token length
   function automatic logic [2:0] finish_set(input logic [2:0] set, input logic sel_args,
                                             input logic [2:0] pos);
      logic [2:0] r;
      logic [2:0] len;
      r = set;
      for (int k = 0; k < KEY_COUNT; k++) begin
         len = sel_args ? ARG_LEN[k] : NAME_LEN[k];
         if (len != pos) begin
            r[k] = 1'b0;
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### design/scl_parser.sv
// Line assembly, tokenizer, keyword matching and LED pin state.
`default_nettype none
module scl_parser #(
   parameter int LINE_MAX = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               word_take,
   input  wire logic [7:0]         word,
   output scl_pkg::result_type     result
);

   localparam int CW = $clog2(LINE_MAX);
   localparam logic [CW-1:0] COUNT_MAX = CW'(LINE_MAX - 1);

   logic [CW-1:0] char_count_ff, char_count_in;
   logic          overflow_ff, overflow_in;
   logic          text_ended_ff, text_ended_in;
   logic          in_token_ff, in_token_in;
   logic [1:0]    token_number_ff, token_number_in;
   logic [2:0]    token_position_ff, token_position_in;
   logic [2:0]    name_match_ff, name_match_in;
   logic [2:0]    arg_match_ff, arg_match_in;
   logic          led_pin_ff, led_pin_in;

   always_comb begin
      logic [1:0]           tn;
      logic [2:0]           nm;
      logic [2:0]           am;
      logic                 have;
      scl_pkg::outcome_type code;
      char_count_in     = char_count_ff;
      overflow_in       = overflow_ff;
      text_ended_in     = text_ended_ff;
      in_token_in       = in_token_ff;
      token_number_in   = token_number_ff;
      token_position_in = token_position_ff;
      name_match_in     = name_match_ff;
      arg_match_in      = arg_match_ff;
      led_pin_in        = led_pin_ff;
      tn   = token_number_ff;
      nm   = name_match_ff;
      am   = arg_match_ff;
      have = 1'b0;
      code = scl_pkg::OUT_LED_ON;

      if ((word == scl_pkg::CHAR_CR) || (word == scl_pkg::CHAR_LF)) begin
         if (overflow_ff) begin
            have = 1'b1;
            code = scl_pkg::OUT_TOO_LONG;
         end else if (char_count_ff != '0) begin
            if (!text_ended_ff && in_token_ff) begin
               if (tn == 2'd0) begin
                  nm = scl_pkg::finish_set(nm, 1'b0, token_position_ff);
               end else if (tn == 2'd1) begin
                  am = scl_pkg::finish_set(am, 1'b1, token_position_ff);
               end
               if (tn != 2'd3) begin
                  tn = tn + 2'd1;
               end
            end
            if (tn != 2'd0) begin
               have = 1'b1;
               if (nm[0]) begin
                  if (tn == 2'd1) begin
                     code = scl_pkg::OUT_LED_USAGE;
                  end else if (am[0]) begin
                     led_pin_in = 1'b0;
                     code = scl_pkg::OUT_LED_ON;
                  end else if (am[1]) begin
                     led_pin_in = 1'b1;
                     code = scl_pkg::OUT_LED_OFF;
                  end else if (am[2]) begin
                     led_pin_in = ~led_pin_ff;
                     code = scl_pkg::OUT_LED_TOGGLE;
                  end else begin
                     code = scl_pkg::OUT_BAD_ARG;
                  end
               end else if (nm[1]) begin
                  code = scl_pkg::OUT_HELP;
               end else if (nm[2]) begin
                  code = scl_pkg::OUT_VERSION;
               end else begin
                  code = scl_pkg::OUT_UNKNOWN;
               end
            end
         end
         char_count_in     = '0;
         overflow_in       = 1'b0;
         text_ended_in     = 1'b0;
         in_token_in       = 1'b0;
         token_number_in   = 2'd0;
         token_position_in = 3'd0;
         name_match_in     = 3'd0;
         arg_match_in      = 3'd0;
      end else if (char_count_ff < COUNT_MAX) begin
         char_count_in = char_count_ff + CW'(1);
         if (!text_ended_ff) begin
            if ((word == scl_pkg::CHAR_NUL) || (word == scl_pkg::CHAR_SPACE)) begin
               if (in_token_ff) begin
                  if (tn == 2'd0) begin
                     name_match_in = scl_pkg::finish_set(nm, 1'b0, token_position_ff);
                  end else if (tn == 2'd1) begin
                     arg_match_in = scl_pkg::finish_set(am, 1'b1, token_position_ff);
                  end
                  in_token_in = 1'b0;
                  if (tn != 2'd3) begin
                     token_number_in = tn + 2'd1;
                  end
               end
               if (word == scl_pkg::CHAR_NUL) begin
                  text_ended_in = 1'b1;
               end
            end else begin
               if (!in_token_ff) begin
                  if (tn == 2'd0) begin
                     nm = 3'b111;
                  end else if (tn == 2'd1) begin
                     am = 3'b111;
                  end
               end
               in_token_in = 1'b1;
               if (tn == 2'd0) begin
                  name_match_in = scl_pkg::narrow_set(nm, 1'b0,
                     in_token_ff ? token_position_ff : 3'd0, word);
               end else if (tn == 2'd1) begin
                  arg_match_in = scl_pkg::narrow_set(am, 1'b1,
                     in_token_ff ? token_position_ff : 3'd0, word);
               end
               if (!in_token_ff) begin
                  token_position_in = 3'd1;
               end else if (token_position_ff != 3'd7) begin
                  token_position_in = token_position_ff + 3'd1;
               end
            end
         end
      end else begin
         overflow_in = 1'b1;
      end

      result.have      = have;
      result.outcome   = code;
      result.led_level = led_pin_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff     <= '0;
         overflow_ff       <= 1'b0;
         text_ended_ff     <= 1'b0;
         in_token_ff       <= 1'b0;
         token_number_ff   <= 2'd0;
         token_position_ff <= 3'd0;
         name_match_ff     <= 3'd0;
         arg_match_ff      <= 3'd0;
         led_pin_ff        <= 1'b1;
      end else if (word_take) begin
         char_count_ff     <= char_count_in;
         overflow_ff       <= overflow_in;
         text_ended_ff     <= text_ended_in;
         in_token_ff       <= in_token_in;
         token_number_ff   <= token_number_in;
         token_position_ff <= token_position_in;
         name_match_ff     <= name_match_in;
         arg_match_ff      <= arg_match_in;
         led_pin_ff        <= led_pin_in;
      end
   end

endmodule
`default_nettype wire

### design/serial_command_line_matcher.sv
// Top level of the serial command line matcher: handshakes and result register.
`default_nettype none
// Takes one received byte per cycle on req_ and assembles lines ended by CR or LF,
// at most LINE_MAX-1 characters. The first token is matched against led, help and
// ver, the second against on, off and toggle; at each line end after a token or an
// overflow one word appears on rsp_ with the outcome code and the active-low LED
// level, in the cycle after the line-end byte is taken. Each taken byte updates
// the line state; req_ready drops only while a result waits and rsp_ready is low.
module serial_command_line_matcher #(
   parameter int LINE_MAX = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [3:0]      rsp_outcome,
   output logic            rsp_led_level
);

   scl_pkg::result_type result;
   logic                take;
   logic                rsp_valid_ff;
   logic [3:0]          rsp_outcome_ff;
   logic                rsp_led_level_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   scl_parser #(
      .LINE_MAX (LINE_MAX)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .word_take (take),
      .word      (req_rx_byte),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && result.have) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && result.have) begin
         rsp_outcome_ff   <= 4'(result.outcome);
         rsp_led_level_ff <= result.led_level;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_outcome   = rsp_outcome_ff;
   assign rsp_led_level = rsp_led_level_ff;

endmodule
`default_nettype wire

### verif/serial_command_line_matcher_tb.sv
// Self-checking testbench for the command line matcher: byte driver, predictor, monitor.
`timescale 1ns / 1ps
module serial_command_line_matcher_tb;

   localparam int LINE_MAX = 64;
   localparam int RANDOM_BYTES_PER_PHASE = 490;
   localparam int KEY_LED = 0;
   localparam int KEY_HELP = 1;
   localparam int KEY_VER = 2;
   localparam int KEY_ON = 0;
   localparam int KEY_OFF = 1;
   localparam int KEY_TOGGLE = 2;

   typedef struct {
      scl_pkg::outcome_type outcome;
      logic                 led;
   } line_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [3:0] rsp_outcome;
   logic       rsp_led_level;

   logic [7:0]      chars_to_send [$];
   line_result_type line_results [$];
   int              bytes_queued = 0;
   int              mismatch_count = 0;
   int              tx_idle_pct = 0;
   int              rx_idle_pct = 0;

   // predicted line state
   int         ln_count = 0;
   logic       ln_overflow = 1'b0;
   logic       ln_text_done = 1'b0;
   logic       ln_in_token = 1'b0;
   logic [1:0] ln_tok_idx = 2'd0;
   logic [2:0] ln_tok_pos = 3'd0;
   logic [2:0] name_cand = 3'd0;
   logic [2:0] arg_cand = 3'd0;
   logic       led_pin = 1'b1;

   string cmd_names [3] = '{"led", "help", "ver"};
   string arg_names [3] = '{"on", "off", "toggle"};
   string name_near [8] = '{"le", "ledd", "LED", "lex", "hel", "helpp", "verr", "ve"};
   string arg_near [8] = '{"o", "onn", "of", "offf", "toggl", "togglee", "togglexyz", "ON"};

   serial_command_line_matcher #(
      .LINE_MAX(LINE_MAX)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_outcome  (rsp_outcome),
      .rsp_led_level(rsp_led_level)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [2:0] prune_by_char(input logic [2:0] cand, input bit of_args,
                                                input logic [2:0] pos, input logic [7:0] c);
      string w;
      for (int k = 0; k < 3; k++) begin
         w = of_args ? arg_names[k] : cmd_names[k];
         if (pos >= w.len() || w[pos] != c) begin
            cand[k] = 1'b0;
         end
      end
      return cand;
   endfunction

   function automatic logic [2:0] prune_by_length(input logic [2:0] cand, input bit of_args,
                                                  input logic [2:0] pos);
      string w;
      for (int k = 0; k < 3; k++) begin
         w = of_args ? arg_names[k] : cmd_names[k];
         if (w.len() != pos) begin
            cand[k] = 1'b0;
         end
      end
      return cand;
   endfunction

   function automatic void close_token();
      if (!ln_in_token) begin
         return;
      end
      if (ln_tok_idx == 2'd0) begin
         name_cand = prune_by_length(name_cand, 1'b0, ln_tok_pos);
      end else if (ln_tok_idx == 2'd1) begin
         arg_cand = prune_by_length(arg_cand, 1'b1, ln_tok_pos);
      end
      ln_in_token = 1'b0;
      if (ln_tok_idx < 2'd3) begin
         ln_tok_idx++;
      end
   endfunction

   // advance the line state by one accepted byte; queue the outcome at a line end that yields one
   function automatic void apply_rx_byte(input logic [7:0] c);
      line_result_type r;
      bit              have;
      have = 1'b0;
      r.outcome = scl_pkg::OUT_LED_ON;
      if (c == scl_pkg::CHAR_CR || c == scl_pkg::CHAR_LF) begin
         if (ln_overflow) begin
            have = 1'b1;
            r.outcome = scl_pkg::OUT_TOO_LONG;
         end else if (ln_count > 0) begin
            if (!ln_text_done) begin
               close_token();
            end
            if (ln_tok_idx > 2'd0) begin
               have = 1'b1;
               if (name_cand[KEY_LED]) begin
                  if (ln_tok_idx < 2'd2) begin
                     r.outcome = scl_pkg::OUT_LED_USAGE;
                  end else if (arg_cand[KEY_ON]) begin
                     led_pin = 1'b0;
                     r.outcome = scl_pkg::OUT_LED_ON;
                  end else if (arg_cand[KEY_OFF]) begin
                     led_pin = 1'b1;
                     r.outcome = scl_pkg::OUT_LED_OFF;
                  end else if (arg_cand[KEY_TOGGLE]) begin
                     led_pin = ~led_pin;
                     r.outcome = scl_pkg::OUT_LED_TOGGLE;
                  end else begin
                     r.outcome = scl_pkg::OUT_BAD_ARG;
                  end
               end else if (name_cand[KEY_HELP]) begin
                  r.outcome = scl_pkg::OUT_HELP;
               end else if (name_cand[KEY_VER]) begin
                  r.outcome = scl_pkg::OUT_VERSION;
               end else begin
                  r.outcome = scl_pkg::OUT_UNKNOWN;
               end
            end
         end
         ln_count = 0;
         ln_overflow = 1'b0;
         ln_text_done = 1'b0;
         ln_in_token = 1'b0;
         ln_tok_idx = 2'd0;
         ln_tok_pos = 3'd0;
         name_cand = 3'd0;
         arg_cand = 3'd0;
         if (have) begin
            r.led = led_pin;
            line_results.push_back(r);
         end
      end else if (ln_count < LINE_MAX - 1) begin
         ln_count++;
         if (!ln_text_done) begin
            if (c == scl_pkg::CHAR_NUL) begin
               close_token();
               ln_text_done = 1'b1;
            end else if (c == scl_pkg::CHAR_SPACE) begin
               close_token();
            end else begin
               if (!ln_in_token) begin
                  ln_in_token = 1'b1;
                  ln_tok_pos = 3'd0;
                  if (ln_tok_idx == 2'd0) begin
                     name_cand = 3'b111;
                  end else if (ln_tok_idx == 2'd1) begin
                     arg_cand = 3'b111;
                  end
               end
               if (ln_tok_idx == 2'd0) begin
                  name_cand = prune_by_char(name_cand, 1'b0, ln_tok_pos, c);
               end else if (ln_tok_idx == 2'd1) begin
                  arg_cand = prune_by_char(arg_cand, 1'b1, ln_tok_pos, c);
               end
               if (ln_tok_pos < 3'd7) begin
                  ln_tok_pos++;
               end
            end
         end
      end else begin
         ln_overflow = 1'b1;
      end
   endfunction

   always @(posedge clock) begin : drive_req
      if (reset) begin
         req_valid <= 1'b0;
         req_rx_byte <= 8'h00;
      end else begin
         if (req_valid && req_ready) begin
            apply_rx_byte(req_rx_byte);
         end
         if (!req_valid || req_ready) begin
            if (chars_to_send.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
               req_valid <= 1'b1;
               req_rx_byte <= chars_to_send.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      line_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (line_results.size() == 0) begin
               $display("%0t: word expected none got outcome=%0d led=%0b", $time,
                        rsp_outcome, rsp_led_level);
               mismatch_count++;
            end else begin
               want = line_results.pop_front();
               if (rsp_outcome !== want.outcome) begin
                  $display("%0t: outcome expected %0d got %0d", $time, want.outcome,
                           rsp_outcome);
                  mismatch_count++;
               end
               if (rsp_led_level !== want.led) begin
                  $display("%0t: led_level expected %0b got %0b", $time, want.led,
                           rsp_led_level);
                  mismatch_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic add_char(input logic [7:0] c);
      chars_to_send.push_back(c);
      bytes_queued++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_char(s[i]);
      end
   endtask

   task automatic add_spaces(input int n);
      for (int i = 0; i < n; i++) begin
         add_char(scl_pkg::CHAR_SPACE);
      end
   endtask

   task automatic add_letters(input int n);
      for (int i = 0; i < n; i++) begin
         add_char(8'($urandom_range(8'h61, 8'h7a)));
      end
   endtask

   task automatic add_noise(input int n);
      for (int i = 0; i < n; i++) begin
         add_char(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic make_random_line();
      int kind;
      int pick;
      int n;
      bit prefixed;
      kind = $urandom_range(99);
      if (kind < 62) begin
         add_spaces($urandom_range(0, 2));
         pick = $urandom_range(99);
         if (pick < 55) begin
            add_text("led");
         end else if (pick < 65) begin
            add_text("help");
         end else if (pick < 75) begin
            add_text("ver");
         end else if (pick < 90) begin
            add_text(name_near[$urandom_range(0, 7)]);
         end else begin
            add_letters($urandom_range(1, 9));
         end
         if ($urandom_range(99) < 85) begin
            add_spaces($urandom_range(1, 3));
            pick = $urandom_range(99);
            if (pick < 70) begin
               add_text(arg_names[$urandom_range(0, 2)]);
            end else if (pick < 88) begin
               add_text(arg_near[$urandom_range(0, 7)]);
            end else begin
               add_letters($urandom_range(1, 9));
            end
         end
         if ($urandom_range(99) < 15) begin
            add_spaces($urandom_range(1, 2));
            add_letters($urandom_range(1, 5));
         end
         if ($urandom_range(99) < 30) begin
            add_spaces($urandom_range(1, 3));
         end
         if ($urandom_range(99) < 8) begin
            add_char(scl_pkg::CHAR_NUL);
            add_noise($urandom_range(0, 4));
         end
      end else if (kind < 72) begin
         // lengths around the line limit
         n = $urandom_range(LINE_MAX - 4, LINE_MAX + 6);
         prefixed = 1'($urandom_range(1));
         if (prefixed) begin
            add_text("led on ");
         end
         for (int i = prefixed ? 7 : 0; i < n; i++) begin
            if ($urandom_range(4) == 0) begin
               add_char(scl_pkg::CHAR_SPACE);
            end else begin
               add_letters(1);
            end
         end
      end else if (kind < 80) begin
         add_spaces($urandom_range(0, 4));
         if ($urandom_range(1)) begin
            add_char(scl_pkg::CHAR_NUL);
            add_noise($urandom_range(0, 6));
         end
      end else begin
         add_noise($urandom_range(1, 12));
      end
      add_char($urandom_range(1) ? scl_pkg::CHAR_CR : scl_pkg::CHAR_LF);
   endtask

   initial begin : run_stimulus
      int start_count;
      tx_idle_pct = 38;
      rx_idle_pct = 47;
      add_text("led on\r");
      add_text("led off\n");
      add_text("led toggle\r");
      add_text("led toggle\n");
      add_text("led\r");
      add_text("led blink\r");
      add_text("help\n");
      add_text("ver\r");
      add_text("foo\n");
      add_text("\r");
      add_text("   \n");
      add_char(scl_pkg::CHAR_NUL);
      add_text("led on\r");
      add_text("led");
      add_char(scl_pkg::CHAR_NUL);
      add_text("on\r");
      add_text("  led   on  extra more\r");
      add_char(8'hFF);
      add_char(scl_pkg::CHAR_CR);
      add_text("led on ");
      for (int i = 7; i < LINE_MAX - 1; i++) begin
         add_char("a");
      end
      add_char(scl_pkg::CHAR_LF);
      add_text("led off ");
      for (int i = 8; i < LINE_MAX; i++) begin
         add_char("b");
      end
      add_char(scl_pkg::CHAR_CR);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct = 38;
               rx_idle_pct = 47;
            end
            1: begin
               tx_idle_pct = 47;
               rx_idle_pct = 38;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         start_count = bytes_queued;
         while (bytes_queued - start_count < RANDOM_BYTES_PER_PHASE) begin
            make_random_line();
         end
         do begin
            @(negedge clock);
         end while (chars_to_send.size() != 0 || req_valid || rsp_valid ||
                    line_results.size() != 0);
      end
      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("serial_command_line_matcher regression: pass");
      end else begin
         $display("serial_command_line_matcher regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("serial_command_line_matcher regression: fail");
      $finish;
   end

endmodule
